// File: rtl/mzz_pkg.sv
`default_nettype none

package mzz_pkg;

  // Field widths fixed by the stream formats
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned LIN_W     = 6;

  // Configuration register file
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(8);

  // Controller to datapath commands
  typedef struct packed {
    logic               wr_en;
    logic [LIN_W-1:0]   wr_addr;
    logic               rd_en;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [CFG_W-1:0]   cols;
    logic               last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rd_ready;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/mzz_elem_if.sv
`default_nettype none

interface mzz_elem_if;
  logic                             valid;
  logic                             ready;
  logic [mzz_pkg::VALUE_W-1:0]      element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

`default_nettype wire

// File: rtl/mzz_result_if.sv
`default_nettype none

interface mzz_result_if;
  logic                             valid;
  logic                             ready;
  logic [mzz_pkg::VALUE_W-1:0]      out_value;
  logic [mzz_pkg::POS_W-1:0]        out_row;
  logic [mzz_pkg::POS_W-1:0]        out_col;
  logic                             is_last;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output is_last, input ready);
  modport sink   (input valid, input out_value, input out_row, input out_col,
                  input is_last, output ready);
endinterface

`default_nettype wire

// File: rtl/mzz_ctrl.sv
`default_nettype none

module mzz_ctrl #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mzz_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mzz_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  output      mzz_pkg::cmd_t                 cmd_o,
  input  wire mzz_pkg::sts_t                 sts_i
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam logic [mzz_pkg::CFG_W-1:0] MAX_DIM_C = mzz_pkg::CFG_W'(MAX_DIM);

  typedef enum logic {
    ST_LOAD,
    ST_SCAN
  } state_e;

  state_e                         state_q;
  logic [mzz_pkg::CFG_W-1:0]      row_cnt_q;
  logic [mzz_pkg::CFG_W-1:0]      col_cnt_q;
  logic [CNT_W-1:0]               load_cnt_q;
  logic [mzz_pkg::POS_W-1:0]      r_q;
  logic [mzz_pkg::POS_W-1:0]      c_q;
  logic                           odd_q;
  logic [CNT_W-1:0]               k_q;

  logic [mzz_pkg::CFG_W-1:0]      rows_w;
  logic [mzz_pkg::CFG_W-1:0]      cols_w;
  logic [mzz_pkg::POS_W-1:0]      row_end;
  logic [mzz_pkg::POS_W-1:0]      col_end;
  logic [CNT_W-1:0]               total_w;
  logic                           load_done;
  logic                           scan_last;
  logic                           issue;
  logic [mzz_pkg::POS_W-1:0]      r_d;
  logic [mzz_pkg::POS_W-1:0]      c_d;
  logic                           odd_d;

  // Clamp dimensions into 1..MAX_DIM
  assign rows_w = (row_cnt_q == '0) ? mzz_pkg::CFG_W'(1) :
                  (row_cnt_q > MAX_DIM_C) ? MAX_DIM_C : row_cnt_q;
  assign cols_w = (col_cnt_q == '0) ? mzz_pkg::CFG_W'(1) :
                  (col_cnt_q > MAX_DIM_C) ? MAX_DIM_C : col_cnt_q;
  assign row_end = mzz_pkg::POS_W'(rows_w - mzz_pkg::CFG_W'(1));
  assign col_end = mzz_pkg::POS_W'(cols_w - mzz_pkg::CFG_W'(1));
  assign total_w = CNT_W'(rows_w) * CNT_W'(cols_w);

  assign in_ready_o = (state_q == ST_LOAD);
  assign load_done  = (load_cnt_q + CNT_W'(1)) == total_w;
  assign scan_last  = (k_q == total_w - CNT_W'(1));
  assign issue      = (state_q == ST_SCAN) && sts_i.rd_ready;

  // Step to the next zigzag position
  always_comb begin
    r_d   = r_q;
    c_d   = c_q;
    odd_d = odd_q;
    if (!odd_q) begin
      if (c_q == col_end) begin
        r_d   = r_q + mzz_pkg::POS_W'(1);
        odd_d = 1'b1;
      end else if (r_q == '0) begin
        c_d   = c_q + mzz_pkg::POS_W'(1);
        odd_d = 1'b1;
      end else begin
        r_d = r_q - mzz_pkg::POS_W'(1);
        c_d = c_q + mzz_pkg::POS_W'(1);
      end
    end else begin
      if (r_q == row_end) begin
        c_d   = c_q + mzz_pkg::POS_W'(1);
        odd_d = 1'b0;
      end else if (c_q == '0) begin
        r_d   = r_q + mzz_pkg::POS_W'(1);
        odd_d = 1'b0;
      end else begin
        r_d = r_q + mzz_pkg::POS_W'(1);
        c_d = c_q - mzz_pkg::POS_W'(1);
      end
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_en   = in_valid_i && in_ready_o;
    cmd_o.wr_addr = mzz_pkg::LIN_W'(load_cnt_q);
    cmd_o.rd_en   = issue;
    cmd_o.row     = r_q;
    cmd_o.col     = c_q;
    cmd_o.cols    = cols_w;
    cmd_o.last    = scan_last;
  end

  // Sequence loading and scanning
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      row_cnt_q  <= mzz_pkg::CFG_DIM_RESET;
      col_cnt_q  <= mzz_pkg::CFG_DIM_RESET;
      load_cnt_q <= '0;
      r_q        <= '0;
      c_q        <= '0;
      odd_q      <= 1'b0;
      k_q        <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_valid_i) begin
            if (load_done) begin
              load_cnt_q <= '0;
              state_q    <= ST_SCAN;
              r_q        <= '0;
              c_q        <= '0;
              odd_q      <= 1'b0;
              k_q        <= '0;
            end else begin
              load_cnt_q <= load_cnt_q + CNT_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            if (scan_last) begin
              state_q <= ST_LOAD;
            end else begin
              r_q   <= r_d;
              c_q   <= c_d;
              odd_q <= odd_d;
              k_q   <= k_q + CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase

      // Any register write drops a partly loaded matrix
      if (cfg_we_i) begin
        case (cfg_index_i)
          mzz_pkg::CFG_ROW_COUNT: row_cnt_q <= cfg_wdata_i;
          mzz_pkg::CFG_COL_COUNT: col_cnt_q <= cfg_wdata_i;
          default: ;
        endcase
        load_cnt_q <= '0;
      end
    end
  end

  a_load_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (load_cnt_q < total_w))
    else $error("load count reached matrix size while loading");

  a_last_returns_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && cmd_o.last && !cfg_we_i) |=> (state_q == ST_LOAD && load_cnt_q == '0))
    else $error("scan did not return to loading after final element");

  a_scan_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((r_q <= row_end) && (c_q <= col_end)))
    else $error("scan position outside matrix");

endmodule

`default_nettype wire

// File: rtl/mzz_datapath.sv
`default_nettype none

module mzz_datapath #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [mzz_pkg::VALUE_W-1:0]  element_value_i,
  input  wire mzz_pkg::cmd_t                cmd_i,
  output      mzz_pkg::sts_t                sts_o,
  mzz_result_if.source                      out_o
);

  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned STORE_W = (DATA_WIDTH < mzz_pkg::VALUE_W) ?
                                    DATA_WIDTH : mzz_pkg::VALUE_W;

  logic [STORE_W-1:0]              mem [DEPTH];

  logic [mzz_pkg::LIN_W-1:0]       rd_lin;
  logic [ADDR_W-1:0]               rd_addr;
  logic [ADDR_W-1:0]               wr_addr;

  logic                            s1_v_q;
  logic [STORE_W-1:0]              s1_data_q;
  logic [mzz_pkg::POS_W-1:0]       s1_row_q;
  logic [mzz_pkg::POS_W-1:0]       s1_col_q;
  logic                            s1_last_q;
  logic                            s1_adv;

  logic                            out_v_q;
  logic [mzz_pkg::VALUE_W-1:0]     out_value_q;
  logic [mzz_pkg::POS_W-1:0]       out_row_q;
  logic [mzz_pkg::POS_W-1:0]       out_col_q;
  logic                            out_last_q;

  // Row-major address of the scan position
  assign rd_lin  = mzz_pkg::LIN_W'(cmd_i.row) * mzz_pkg::LIN_W'(cmd_i.cols)
                 + mzz_pkg::LIN_W'(cmd_i.col);
  assign rd_addr = rd_lin[ADDR_W-1:0];
  assign wr_addr = cmd_i.wr_addr[ADDR_W-1:0];

  assign s1_adv         = s1_v_q && (!out_v_q || out_o.ready);
  assign sts_o.rd_ready = !s1_v_q || s1_adv;

  // Element buffer with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= element_value_i[STORE_W-1:0];
    end
    if (cmd_i.rd_en) begin
      s1_data_q <= mem[rd_addr];
      s1_row_q  <= cmd_i.row;
      s1_col_q  <= cmd_i.col;
      s1_last_q <= cmd_i.last;
    end
  end

  // Track read stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  // Output register: hold while stalled, advance when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q <= mzz_pkg::VALUE_W'($signed(s1_data_q));
      out_row_q   <= s1_row_q;
      out_col_q   <= s1_col_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.out_value = out_value_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.is_last   = out_last_q;

  a_no_read_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !out_o.ready) |-> !cmd_i.rd_en)
    else $error("buffer read issued into a full pipeline");

  a_no_load_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en) |-> !cmd_i.rd_en)
    else $error("element write overlaps scan read");

endmodule

`default_nettype wire

// File: rtl/matrix_zigzag_reorder_core.sv
`default_nettype none

// Elements are taken only while no matrix is being scanned; results of the previous matrix
// may still drain while the next one loads. Each zigzag read passes the buffer read stage
// and then the output register, giving one result per cycle while the receiver holds ready.
// Loading of the next matrix starts once the last read issues.
// Reset clears control state and sets both dimensions to 8; buffer contents stay undefined.
module matrix_zigzag_reorder_core #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mzz_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mzz_pkg::CFG_W-1:0]     cfg_wdata_i,
  mzz_elem_if.sink                           elem_in_i,
  mzz_result_if.source                       elem_out_o
);

  mzz_pkg::cmd_t cmd;
  mzz_pkg::sts_t sts;
  logic          in_ready;

  assign elem_in_i.ready = in_ready;

  mzz_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (elem_in_i.valid),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mzz_datapath #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_value_i (elem_in_i.element_value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_o           (elem_out_o)
  );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mzz_pkg::*;

  localparam int unsigned MAX_DIM      = 8;
  localparam int unsigned STORE_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned RAND_ITEMS   = 60;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned STALL_CYC    = 300;

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic               last;
  } zz_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  mzz_elem_if   elem_if ();
  mzz_result_if res_if ();

  matrix_zigzag_reorder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .elem_in_i   (elem_if),
    .elem_out_o  (res_if)
  );

  // Shadow copy of the block state
  logic [VALUE_W-1:0] shadow_store [STORE_DEPTH];
  logic [CFG_W-1:0]   row_count_q = CFG_DIM_RESET;
  logic [CFG_W-1:0]   col_count_q = CFG_DIM_RESET;
  int unsigned        load_cnt    = 0;

  zz_result_t zigzag_expect_q [$];
  int unsigned mismatch_cnt  = 0;
  bit          tx_idle_on    = 1'b1;
  bit          rx_idle_on    = 1'b1;
  int unsigned stall_req_cnt = 0;
  int unsigned stall_ack_cnt = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic void queue_scan_entry(int unsigned r, int unsigned c, int unsigned cols,
                                           bit last);
    zz_result_t res;
    res.value = shadow_store[(r * cols + c) % STORE_DEPTH];
    res.row   = POS_W'(r);
    res.col   = POS_W'(c);
    res.last  = last;
    zigzag_expect_q.push_back(res);
  endfunction

  // Store one accepted element; queue the zigzag scan once the matrix is full
  function automatic void load_element(logic [VALUE_W-1:0] v);
    int unsigned rows, cols, total, rlo, rhi, emitted;
    int r;
    rows  = clamp_dim(row_count_q);
    cols  = clamp_dim(col_count_q);
    total = rows * cols;
    shadow_store[load_cnt % STORE_DEPTH] = v;
    load_cnt++;
    if (load_cnt < total) return;
    load_cnt = 0;
    emitted  = 0;
    for (int unsigned d = 0; d + 1 < rows + cols; d++) begin
      rlo = (d > cols - 1) ? d - (cols - 1) : 0;
      rhi = (d < rows - 1) ? d : rows - 1;
      if (d[0] == 1'b0) begin
        // even diagonal: walk from lower left up to the right
        for (r = int'(rhi); r >= int'(rlo); r--) begin
          emitted++;
          queue_scan_entry(r, d - r, cols, emitted == total);
        end
      end else begin
        for (r = int'(rlo); r <= int'(rhi); r++) begin
          emitted++;
          queue_scan_entry(r, d - r, cols, emitted == total);
        end
      end
    end
  endfunction

  // Receiver: random ready, plus a long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req_cnt != stall_ack_cnt) begin
        stall_ack_cnt = stall_req_cnt;
        res_if.ready  = 1'b0;
        repeat (STALL_CYC) @(negedge clk_i);
      end
      res_if.ready = rx_idle_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    zz_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (zigzag_expect_q.size() == 0) begin
        $error("unexpected result: out_value=%h out_row=%0d out_col=%0d is_last=%0b",
               res_if.out_value, res_if.out_row, res_if.out_col, res_if.is_last);
        mismatch_cnt++;
      end else begin
        want = zigzag_expect_q.pop_front();
        if (res_if.out_value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, res_if.out_value);
          mismatch_cnt++;
        end
        if (res_if.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, res_if.out_row);
          mismatch_cnt++;
        end
        if (res_if.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, res_if.out_col);
          mismatch_cnt++;
        end
        if (res_if.is_last !== want.last) begin
          $error("is_last: expected %0b, got %0b", want.last, res_if.is_last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Send one element; entered and left at a falling edge, valid stays high
  task automatic send_element(logic [VALUE_W-1:0] v);
    if (tx_idle_on && $urandom_range(0, 99) < 25) begin
      elem_if.valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    elem_if.valid         = 1'b1;
    elem_if.element_value = v;
    do @(posedge clk_i); while (!elem_if.ready);
    load_element(v);
    @(negedge clk_i);
  endtask

  task automatic sender_idle();
    elem_if.valid = 1'b0;
  endtask

  // Hold until every expected result has arrived and the block has settled
  task automatic wait_drained();
    sender_idle();
    while (zigzag_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_ROW_COUNT) row_count_q = val;
    else if (idx == CFG_COL_COUNT) col_count_q = val;
    load_cnt = 0;
  endtask

  task automatic set_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    wait_drained();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_ROW_COUNT, rows);
      write_reg(CFG_COL_COUNT, cols);
    end else begin
      write_reg(CFG_COL_COUNT, cols);
      write_reg(CFG_ROW_COUNT, rows);
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_matrix();
    int unsigned total;
    total = clamp_dim(row_count_q) * clamp_dim(col_count_q);
    repeat (total) send_element(pick_value());
  endtask

  // Reset dimensions are 8x8; lead with the value extremes
  task automatic test_reset_dims();
    send_element({1'b1, {(VALUE_W-1){1'b0}}});
    send_element({1'b0, {(VALUE_W-1){1'b1}}});
    send_element('0);
    send_element('1);
    send_element({(VALUE_W/2){2'b10}});
    send_element({(VALUE_W/2){2'b01}});
    repeat (58) send_element($urandom());
    wait_drained();
  endtask

  // 1x1 matrices, and zero dimensions acting as one
  task automatic test_single_element();
    set_dims(CFG_W'(1), CFG_W'(1));
    send_element({1'b1, {(VALUE_W-1){1'b0}}});
    send_element({1'b0, {(VALUE_W-1){1'b1}}});
    set_dims('0, '0);
    send_element('1);
  endtask

  task automatic test_rect_shapes();
    set_dims(CFG_W'(2), CFG_W'(3));
    send_element('0);
    send_element({(VALUE_W/2){2'b10}});
    send_element({(VALUE_W/2){2'b01}});
    repeat (3) send_element($urandom());
    set_dims(CFG_W'(3), CFG_W'(2));
    repeat (6) send_element(pick_value());
  endtask

  // A register write drops a partly loaded matrix, also at a spare index
  task automatic test_dropped_load();
    set_dims(CFG_W'(2), CFG_W'(2));
    repeat (3) send_element($urandom());
    wait_drained();
    write_reg(CFG_SPARE_A, CFG_W'(5));
    repeat (4) send_element($urandom());
    wait_drained();
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_dims(CFG_W'(3), CFG_W'(4));
    repeat (3) send_matrix();
    set_dims(CFG_W'(15), CFG_W'(1));
    send_matrix();
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering; input must stall
  task automatic test_output_stall();
    set_dims(CFG_W'(4), CFG_W'(4));
    stall_req_cnt++;
    repeat (2) send_matrix();
    wait_drained();
  endtask

  task automatic test_random_shapes();
    int unsigned sent, total, pick;
    logic [CFG_W-1:0] rows, cols;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        rows = $urandom_range(0, 1) ? CFG_W'($urandom_range(8, 15)) : CFG_W'($urandom_range(0, 1));
        cols = $urandom_range(0, 1) ? CFG_W'($urandom_range(8, 15)) : CFG_W'($urandom_range(0, 1));
      end else if (pick == 1) begin
        rows = CFG_W'($urandom_range(1, 8));
        cols = CFG_W'($urandom_range(1, 8));
      end else begin
        rows = CFG_W'($urandom_range(1, 4));
        cols = CFG_W'($urandom_range(1, 4));
      end
      set_dims(rows, cols);
      if ($urandom_range(0, 7) == 0) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                               CFG_W'($urandom_range(0, 15)));
      total = clamp_dim(rows) * clamp_dim(cols);
      repeat ($urandom_range(1, 3)) begin
        send_matrix();
        sent += total;
      end
      // broken sequence: partial load, dropped by the next register write
      if (total > 1 && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, total - 1)) send_element($urandom());
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = CFG_ROW_COUNT;
    cfg_wdata_i           = '0;
    elem_if.valid         = 1'b0;
    elem_if.element_value = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_dims();
    test_single_element();
    test_rect_shapes();
    test_dropped_load();
    test_back_to_back();
    test_output_stall();
    test_random_shapes();

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
